// ----- rtl/core/mpcg_pkg.sv -----
// Shared constants, types and table functions for the microstep phase current generator.
`default_nettype none

package mpcg_pkg;

  // command codes
  localparam logic [1:0] KIND_DRIVE = 2'd0;
  localparam logic [1:0] KIND_SLEEP = 2'd1;
  localparam logic [1:0] KIND_BRAKE = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int TABLE_SIZE      = 1024;
  localparam int AMPLITUDE_SHIFT = 12;
  localparam int PHASE_W         = $clog2(TABLE_SIZE);
  localparam int QUARTER         = TABLE_SIZE / 4;
  localparam int QOFS_W          = PHASE_W - 2;

  localparam int KIND_W = 2;
  localparam int COUNT_W = 10;
  localparam int CUR_W  = 13;
  localparam int MAG_W  = 12;
  localparam int DUTY_W = 10;

  localparam logic [MAG_W-1:0] MAX_MA    = 12'd3300;
  localparam logic [MAG_W-1:0] TAB_PEAK  = 12'hFFF;
  localparam logic [12:0]      SCALE_NUM = 13'd5083;
  localparam int               SCALE_W   = MAG_W + 13;
  localparam int               PROD_W    = 2 * MAG_W;

  localparam real PI       = 3.14159265358979323846;
  localparam real STEP_RAD = 2.0 * PI / real'(TABLE_SIZE);

  typedef logic [MAG_W-1:0] qtab_t [QUARTER];

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } tab_val_t;

  // first quadrant of round(4095*sin(2*pi*i/TABLE_SIZE)), built at elaboration
  function automatic qtab_t build_qtab();
    qtab_t t;
    real   a;
    for (int k = 0; k < QUARTER; k++) begin
      a = 4095.0 * $sin(STEP_RAD * real'(k));
      t[k] = MAG_W'($rtoi(a + 0.5));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // fold the full period onto the quarter table
  function automatic tab_val_t sine_lookup(input logic [PHASE_W-1:0] idx);
    tab_val_t         r;
    logic [1:0]       q;
    logic [QOFS_W-1:0] o;
    q = idx[PHASE_W-1 -: 2];
    o = idx[QOFS_W-1:0];
    if (q[0]) begin
      if (o == '0) r.mag = TAB_PEAK;
      else         r.mag = QTAB[QOFS_W'(-o)];
    end else begin
      r.mag = QTAB[o];
    end
    r.neg = q[1] && (r.mag != '0);
    return r;
  endfunction

  // scale table magnitude by amplitude, saturate at 12 bits, drop two bits
  function automatic logic [DUTY_W-1:0] coil_duty(input logic [MAG_W-1:0] amp,
                                                 input logic [MAG_W-1:0] mag);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;
    logic [MAG_W-1:0]  v;
    prod    = amp * mag;
    shifted = prod >> AMPLITUDE_SHIFT;
    if (shifted > PROD_W'(TAB_PEAK)) v = TAB_PEAK;
    else                             v = shifted[MAG_W-1:0];
    return v[MAG_W-1 -: DUTY_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/microstep_phase_current_generator.sv -----
// Microstep phase current generator: three-stage pipeline from command word to bridge settings.
`default_nettype none

// One command word enters per cycle unless the output stalls, and passes
// through the stage registers in order. Stage one takes the current
// magnitude and the two phase indices, stage two reads the quarter-wave sine
// table and scales the current, stage three does the two coil multiplies and
// holds the result in the output register. The whole pipeline advances when
// the output register is empty or being taken, so in_ready follows out_ready
// within the same cycle. Sleep gives zero duty with all pins low, brake zero
// duty with all pins high, and the unused kind code behaves as sleep.
module microstep_phase_current_generator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [mpcg_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [mpcg_pkg::COUNT_W-1:0]       in_phase_count,
  input  wire logic signed [mpcg_pkg::CUR_W-1:0]  in_current_ma,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [mpcg_pkg::DUTY_W-1:0]        out_duty_a,
  output      logic [mpcg_pkg::DUTY_W-1:0]        out_duty_b,
  output      logic                              out_a_plus,
  output      logic                              out_a_minus,
  output      logic                              out_b_plus,
  output      logic                              out_b_minus
);

  logic advance;

  // stage one
  logic                                s1_valid_r;
  logic [mpcg_pkg::KIND_W-1:0]         s1_kind_r;
  logic [mpcg_pkg::PHASE_W-1:0]        s1_idx_a_r, s1_idx_b_r;
  logic [mpcg_pkg::MAG_W-1:0]          s1_mag_r;
  logic [mpcg_pkg::CUR_W-1:0]          abs_cur;
  logic [mpcg_pkg::MAG_W-1:0]          s1_mag_nxt;
  logic [mpcg_pkg::PHASE_W-1:0]        idx_b_nxt;

  // stage two
  logic                                s2_valid_r;
  logic [mpcg_pkg::KIND_W-1:0]         s2_kind_r;
  mpcg_pkg::tab_val_t                  s2_tab_a_r, s2_tab_b_r;
  logic [mpcg_pkg::MAG_W-1:0]          s2_amp_r;
  logic [mpcg_pkg::SCALE_W-1:0]        scaled;

  // output stage
  logic                                out_valid_r;
  logic [mpcg_pkg::DUTY_W-1:0]         duty_a_r, duty_b_r, duty_a_nxt, duty_b_nxt;
  logic                                a_plus_r, a_minus_r, b_plus_r, b_minus_r;
  logic                                a_plus_nxt, a_minus_nxt, b_plus_nxt, b_minus_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  always_comb begin
    // two's complement negate; the most negative code maps to 4096 unsigned
    abs_cur = in_current_ma[mpcg_pkg::CUR_W-1] ? mpcg_pkg::CUR_W'(-in_current_ma)
                                               : mpcg_pkg::CUR_W'(in_current_ma);
    if (abs_cur > mpcg_pkg::CUR_W'(mpcg_pkg::MAX_MA)) s1_mag_nxt = mpcg_pkg::MAX_MA;
    else s1_mag_nxt = abs_cur[mpcg_pkg::MAG_W-1:0];
    idx_b_nxt = mpcg_pkg::PHASE_W'(in_phase_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
    if (advance) begin
      s1_kind_r  <= in_kind;
      s1_mag_r   <= s1_mag_nxt;
      s1_idx_b_r <= idx_b_nxt;
      s1_idx_a_r <= idx_b_nxt + mpcg_pkg::PHASE_W'(mpcg_pkg::QUARTER);
    end
  end

  assign scaled = s1_mag_r * mpcg_pkg::SCALE_NUM;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
    if (advance) begin
      s2_kind_r  <= s1_kind_r;
      s2_tab_a_r <= mpcg_pkg::sine_lookup(s1_idx_a_r);
      s2_tab_b_r <= mpcg_pkg::sine_lookup(s1_idx_b_r);
      s2_amp_r   <= scaled[12 +: mpcg_pkg::MAG_W];
    end
  end

  always_comb begin
    duty_a_nxt  = '0;
    duty_b_nxt  = '0;
    a_plus_nxt  = 1'b0;
    a_minus_nxt = 1'b0;
    b_plus_nxt  = 1'b0;
    b_minus_nxt = 1'b0;
    priority if (s2_kind_r == mpcg_pkg::KIND_DRIVE) begin
      duty_a_nxt  = mpcg_pkg::coil_duty(s2_amp_r, s2_tab_a_r.mag);
      duty_b_nxt  = mpcg_pkg::coil_duty(s2_amp_r, s2_tab_b_r.mag);
      // zero entry drives both pins high
      a_plus_nxt  = !s2_tab_a_r.neg;
      a_minus_nxt = s2_tab_a_r.neg || (s2_tab_a_r.mag == '0);
      b_plus_nxt  = !s2_tab_b_r.neg;
      b_minus_nxt = s2_tab_b_r.neg || (s2_tab_b_r.mag == '0);
    end else if (s2_kind_r == mpcg_pkg::KIND_BRAKE) begin
      a_plus_nxt  = 1'b1;
      a_minus_nxt = 1'b1;
      b_plus_nxt  = 1'b1;
      b_minus_nxt = 1'b1;
    end else begin
      // sleep and the unused code: all pins low
      a_plus_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
    if (advance) begin
      duty_a_r  <= duty_a_nxt;
      duty_b_r  <= duty_b_nxt;
      a_plus_r  <= a_plus_nxt;
      a_minus_r <= a_minus_nxt;
      b_plus_r  <= b_plus_nxt;
      b_minus_r <= b_minus_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty_a  = duty_a_r;
  assign out_duty_b  = duty_b_r;
  assign out_a_plus  = a_plus_r;
  assign out_a_minus = a_minus_r;
  assign out_b_plus  = b_plus_r;
  assign out_b_minus = b_minus_r;

endmodule

`default_nettype wire

// ----- tb/sv/tb_microstep_phase_current_generator.sv -----
// Testbench for the microstep phase current generator: scoreboard class and top module.
`default_nettype none

typedef struct {
  logic [mpcg_pkg::DUTY_W-1:0] duty_a;
  logic [mpcg_pkg::DUTY_W-1:0] duty_b;
  logic                        a_plus;
  logic                        a_minus;
  logic                        b_plus;
  logic                        b_minus;
} bridge_setting_t;

class phase_current_scoreboard;
  logic signed [12:0] sine_lut [mpcg_pkg::TABLE_SIZE];
  bridge_setting_t    pending_settings [$];
  int                 errors;

  // (a*b) >> 60 over the full 128-bit product
  function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series of sin in Q60, argument within the first quadrant
  function logic [63:0] sin_q60(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 14; n++) begin
      term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    return sum;
  endfunction

  function new();
    logic [63:0] pi_q60;
    logic [63:0] step;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    bit          neg;
    pi_q60 = 64'h3243F6A8885A308D;
    step   = pi_q60 / 64'(mpcg_pkg::TABLE_SIZE);
    rem    = pi_q60 % 64'(mpcg_pkg::TABLE_SIZE);
    errors = 0;
    for (int i = 0; i < mpcg_pkg::TABLE_SIZE; i++) begin
      x   = step * 64'(2 * i) + (rem * 64'(2 * i)) / 64'(mpcg_pkg::TABLE_SIZE);
      neg = 1'b0;
      if (x > pi_q60) begin
        x   = x - pi_q60;
        neg = 1'b1;
      end
      if (x > pi_q60 / 2) x = pi_q60 - x;
      s = sin_q60(x);
      v = ((s >> 20) * 64'd4095 + (64'd1 << 39)) >> 40;
      if (v > 64'd4095) v = 64'd4095;
      sine_lut[i] = neg ? -13'(v) : 13'(v);
    end
  endfunction

  function logic [mpcg_pkg::DUTY_W-1:0] coil_to_duty(int amp, logic signed [12:0] t);
    int m;
    int v;
    m = (t < 0) ? -int'(t) : int'(t);
    v = (amp * m) >> mpcg_pkg::AMPLITUDE_SHIFT;
    if (v > int'(mpcg_pkg::TAB_PEAK)) v = int'(mpcg_pkg::TAB_PEAK);
    return mpcg_pkg::DUTY_W'(v >> 2);
  endfunction

  // {plus, minus} from the sign of a table entry
  function logic [1:0] pins_for(logic signed [12:0] t);
    if (t > 0)      return 2'b10;
    else if (t < 0) return 2'b01;
    else            return 2'b11;
  endfunction

  function void note_command(logic [mpcg_pkg::KIND_W-1:0] kind,
                             logic [mpcg_pkg::COUNT_W-1:0] phase,
                             logic signed [mpcg_pkg::CUR_W-1:0] cur);
    bridge_setting_t    w;
    int                 mag;
    int                 amp;
    int                 ia;
    logic signed [12:0] ta;
    logic signed [12:0] tb;
    logic [1:0]         pa;
    logic [1:0]         pb;
    if (kind != mpcg_pkg::KIND_DRIVE) begin
      // brake shorts the windings, sleep and the spare code release them
      w.duty_a  = '0;
      w.duty_b  = '0;
      w.a_plus  = (kind == mpcg_pkg::KIND_BRAKE);
      w.a_minus = (kind == mpcg_pkg::KIND_BRAKE);
      w.b_plus  = (kind == mpcg_pkg::KIND_BRAKE);
      w.b_minus = (kind == mpcg_pkg::KIND_BRAKE);
    end else begin
      mag = (cur < 0) ? -int'(cur) : int'(cur);
      if (mag > int'(mpcg_pkg::MAX_MA)) mag = int'(mpcg_pkg::MAX_MA);
      amp = ((mag * int'(mpcg_pkg::SCALE_NUM)) >> 12) & int'(mpcg_pkg::TAB_PEAK);
      ia  = (int'(phase) + mpcg_pkg::QUARTER) % mpcg_pkg::TABLE_SIZE;
      ta  = sine_lut[ia];
      tb  = sine_lut[int'(phase) % mpcg_pkg::TABLE_SIZE];
      pa  = pins_for(ta);
      pb  = pins_for(tb);
      w.duty_a  = coil_to_duty(amp, ta);
      w.duty_b  = coil_to_duty(amp, tb);
      w.a_plus  = pa[1];
      w.a_minus = pa[0];
      w.b_plus  = pb[1];
      w.b_minus = pb[0];
    end
    pending_settings.push_back(w);
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_word(bridge_setting_t got);
    bridge_setting_t want;
    if (pending_settings.size() == 0) begin
      report_mismatch("unexpected word", 1, 0);
    end else begin
      want = pending_settings.pop_front();
      if (got.duty_a !== want.duty_a)
        report_mismatch("duty_a", int'(got.duty_a), int'(want.duty_a));
      if (got.duty_b !== want.duty_b)
        report_mismatch("duty_b", int'(got.duty_b), int'(want.duty_b));
      if (got.a_plus !== want.a_plus)
        report_mismatch("a_plus", int'(got.a_plus), int'(want.a_plus));
      if (got.a_minus !== want.a_minus)
        report_mismatch("a_minus", int'(got.a_minus), int'(want.a_minus));
      if (got.b_plus !== want.b_plus)
        report_mismatch("b_plus", int'(got.b_plus), int'(want.b_plus));
      if (got.b_minus !== want.b_minus)
        report_mismatch("b_minus", int'(got.b_minus), int'(want.b_minus));
    end
  endtask

  function int pending();
    return pending_settings.size();
  endfunction
endclass

module tb_microstep_phase_current_generator;
  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [mpcg_pkg::KIND_W-1:0]         in_kind = mpcg_pkg::KIND_DRIVE;
  logic [mpcg_pkg::COUNT_W-1:0]        in_phase_count = '0;
  logic signed [mpcg_pkg::CUR_W-1:0]   in_current_ma = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [mpcg_pkg::DUTY_W-1:0]         out_duty_a;
  logic [mpcg_pkg::DUTY_W-1:0]         out_duty_b;
  logic                                out_a_plus;
  logic                                out_a_minus;
  logic                                out_b_plus;
  logic                                out_b_minus;

  phase_current_scoreboard sb;
  int tx_idle_pct = 24;
  int rx_idle_pct = 64;
  int hold_left = 0;
  bit stall_request = 1'b0;

  microstep_phase_current_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_phase_count (in_phase_count),
    .in_current_ma  (in_current_ma),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_duty_a     (out_duty_a),
    .out_duty_b     (out_duty_b),
    .out_a_plus     (out_a_plus),
    .out_a_minus    (out_a_minus),
    .out_b_plus     (out_b_plus),
    .out_b_minus    (out_b_minus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: take result words, hold off on request for a long stretch
  always @(posedge clk) begin
    bridge_setting_t got;
    if (rst_n && out_valid && out_ready) begin
      got.duty_a  = out_duty_a;
      got.duty_b  = out_duty_b;
      got.a_plus  = out_a_plus;
      got.a_minus = out_a_minus;
      got.b_plus  = out_b_plus;
      got.b_minus = out_b_minus;
      sb.check_word(got);
    end
    if (stall_request) begin
      hold_left     = 300;
      stall_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task send_command(logic [mpcg_pkg::KIND_W-1:0] kind, logic [mpcg_pkg::COUNT_W-1:0] phase,
                    logic signed [mpcg_pkg::CUR_W-1:0] cur);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_phase_count <= phase;
    in_current_ma  <= cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(kind, phase, cur);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task send_random_command();
    logic [mpcg_pkg::KIND_W-1:0]       kind;
    logic [mpcg_pkg::COUNT_W-1:0]      phase;
    logic signed [mpcg_pkg::CUR_W-1:0] cur;
    int                                r;
    r = $urandom_range(99);
    if (r < 72)      kind = mpcg_pkg::KIND_DRIVE;
    else if (r < 82) kind = mpcg_pkg::KIND_SLEEP;
    else if (r < 92) kind = mpcg_pkg::KIND_BRAKE;
    else             kind = mpcg_pkg::KIND_SPARE;
    // lean on the quadrant seams of the table
    if ($urandom_range(99) < 15)
      phase = mpcg_pkg::COUNT_W'($urandom_range(3) * mpcg_pkg::QUARTER
                                 + $urandom_range(2) - 1);
    else
      phase = mpcg_pkg::COUNT_W'($urandom_range(mpcg_pkg::TABLE_SIZE - 1));
    r = $urandom_range(99);
    if (r < 10)      cur = mpcg_pkg::CUR_W'($urandom);
    else if (r < 15) cur = $urandom_range(1) ? mpcg_pkg::CUR_W'(3300) : -mpcg_pkg::CUR_W'(3300);
    else             cur = mpcg_pkg::CUR_W'(int'($urandom_range(6600)) - 3300);
    send_command(kind, phase, cur);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: extremes, quadrant seams, saturation and every kind
    send_command(mpcg_pkg::KIND_DRIVE, 10'd0, 13'sd3300);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd256, 13'sd3300);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd512, -13'sd3300);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd768, 13'sd3300);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd1023, 13'sd3300);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd1, 13'sd1);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd255, -13'sd1);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd257, 13'sd3299);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd511, 13'sd2000);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd513, 13'sd2000);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd767, 13'sd1234);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd769, 13'sd1234);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd128, 13'sd0);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd384, 13'sd4095);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd640, -13'sd4096);
    send_command(mpcg_pkg::KIND_DRIVE, 10'd896, 13'sd3301);
    send_command(mpcg_pkg::KIND_DRIVE, 10'h2AA, 13'h0AAA);
    send_command(mpcg_pkg::KIND_DRIVE, 10'h155, 13'h1555);
    send_command(mpcg_pkg::KIND_SLEEP, 10'd1023, 13'sd3300);
    send_command(mpcg_pkg::KIND_BRAKE, 10'd512, -13'sd3300);
    send_command(mpcg_pkg::KIND_SPARE, 10'h3FF, 13'h1FFF);
    send_command(mpcg_pkg::KIND_SLEEP, 10'd0, 13'sd0);
    send_command(mpcg_pkg::KIND_BRAKE, 10'd0, 13'sd0);

    for (int i = 0; i < 650; i++) send_random_command();
    tx_idle_pct = 64;
    rx_idle_pct = 24;
    for (int i = 0; i < 650; i++) send_random_command();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 650; i++) begin
      // hold the receiver off so the pipeline fills and stalls its input
      if (i == 100) stall_request = 1'b1;
      send_random_command();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0) $display("tb_microstep_phase_current_generator OK");
    else                $display("tb_microstep_phase_current_generator NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_microstep_phase_current_generator NOT OK");
    $finish;
  end
endmodule

`default_nettype wire
